@@ design/svsl_pkg.sv @@
package svsl_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned NUM_JOINTS_DEF = 16;
  localparam int unsigned JOINT_W        = 4;
  localparam int unsigned ANGLE_W        = 16;
  localparam int unsigned SCALE_W        = 15;
  localparam int unsigned COEF_W         = 16;
  localparam int unsigned SLEW_W         = 15;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned STEP_W         = 3;

  // Register reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 15'd4096;
  localparam logic [COEF_W-1:0]  COEF_RST  = 16'd0;
  localparam logic [SLEW_W-1:0]  SLEW_RST  = 15'd32767;

  // Plus and minus one in Q4.12
  localparam logic signed [ANGLE_W-1:0] POS_ONE_Q12 = 16'sd4096;
  localparam logic signed [ANGLE_W-1:0] NEG_ONE_Q12 = -16'sd4096;

  // Operation codes of an input item
  localparam logic OP_ACTION = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTION_SCALE = 2'd0,
    CFG_SMOOTH_COEF  = 2'd1,
    CFG_SLEW_STEP    = 2'd2
  } cfg_idx_e;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    logic [SCALE_W-1:0] action_scale;
    logic [COEF_W-1:0]  smooth_coef;
    logic [SLEW_W-1:0]  slew_step;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [JOINT_W-1:0] joint;
    angle_t             action_value;
    angle_t             stand_angle;
    angle_t             limit_low;
    angle_t             limit_high;
  } in_item_t;

  typedef struct packed {
    logic [JOINT_W-1:0] joint_out;
    angle_t             target_angle;
    logic               action_clipped;
    logic               slew_limited;
  } out_item_t;

  // One joint's stored state
  typedef struct packed {
    angle_t target;
    angle_t stand;
    angle_t low;
    angle_t high;
  } row_t;

  // Datapath operations selected by the control word
  typedef enum logic [2:0] {
    DP_FETCH  = 3'd0,
    DP_SCALE  = 3'd1,
    DP_RAW    = 3'd2,
    DP_BLEND  = 3'd3,
    DP_SMOOTH = 3'd4,
    DP_SLEW   = 3'd5,
    DP_SHORT  = 3'd6
  } dp_op_e;

  // Jump conditions of the sequencer
  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,
    JC_GOTO     = 3'd1,
    JC_SHORT    = 3'd2,
    JC_WAIT_IN  = 3'd3,
    JC_WAIT_OUT = 3'd4
  } jcond_e;

  localparam step_t STEP_FETCH    = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_RAW      = 3'd2;
  localparam step_t STEP_BLEND    = 3'd3;
  localparam step_t STEP_SMOOTH   = 3'd4;
  localparam step_t STEP_SLEW     = 3'd5;
  localparam step_t STEP_SHORT    = 3'd6;

  typedef struct packed {
    dp_op_e op;
    jcond_e cond;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    dp_op_e op;
    logic   in_ready;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic short_path;
    logic out_free;
  } stat_t;

  // Control program: one word per step
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    begin
      unique case (s)
        STEP_FETCH:    w = '{op: DP_FETCH,  cond: JC_WAIT_IN,  target: STEP_DISPATCH};
        STEP_DISPATCH: w = '{op: DP_SCALE,  cond: JC_SHORT,    target: STEP_SHORT};
        STEP_RAW:      w = '{op: DP_RAW,    cond: JC_NEXT,     target: STEP_FETCH};
        STEP_BLEND:    w = '{op: DP_BLEND,  cond: JC_NEXT,     target: STEP_FETCH};
        STEP_SMOOTH:   w = '{op: DP_SMOOTH, cond: JC_NEXT,     target: STEP_FETCH};
        STEP_SLEW:     w = '{op: DP_SLEW,   cond: JC_WAIT_OUT, target: STEP_FETCH};
        STEP_SHORT:    w = '{op: DP_SHORT,  cond: JC_WAIT_OUT, target: STEP_FETCH};
        default:       w = '{op: DP_FETCH,  cond: JC_GOTO,     target: STEP_FETCH};
      endcase
      return w;
    end
  endfunction

endpackage

@@ design/svsl_if.sv @@
interface svsl_in_if;
  import svsl_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [JOINT_W-1:0] joint;
  angle_t             action_value;
  angle_t             stand_angle;
  angle_t             limit_low;
  angle_t             limit_high;

  modport source (output valid, operation, joint, action_value, stand_angle, limit_low,
                  limit_high, input ready);
  modport sink (input valid, operation, joint, action_value, stand_angle, limit_low,
                limit_high, output ready);
endinterface

interface svsl_out_if;
  import svsl_pkg::*;
  logic               valid;
  logic               ready;
  logic [JOINT_W-1:0] joint_out;
  angle_t             target_angle;
  logic               action_clipped;
  logic               slew_limited;

  modport source (output valid, joint_out, target_angle, action_clipped, slew_limited,
                  input ready);
  modport sink (input valid, joint_out, target_angle, action_clipped, slew_limited,
                output ready);
endinterface

interface svsl_cfg_if;
  import svsl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/svsl_useq.sv @@
module svsl_useq
  import svsl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  step_t  step_q, step_d;
  ucode_t word;

  assign word = ucode_rom(step_q);

  // Next step from the jump condition of the current word
  always_comb begin
    unique case (word.cond)
      JC_NEXT:     step_d = step_q + step_t'(1);
      JC_GOTO:     step_d = word.target;
      JC_SHORT:    step_d = stat_i.short_path ? word.target : step_q + step_t'(1);
      JC_WAIT_IN:  step_d = stat_i.in_valid ? word.target : step_q;
      JC_WAIT_OUT: step_d = stat_i.out_free ? word.target : step_q;
      default:     step_d = STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_FETCH;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op       = word.op;
  assign ctrl_o.in_ready = (word.cond == JC_WAIT_IN);

endmodule

@@ design/svsl_dp.sv @@
module svsl_dp
  import svsl_pkg::*;
#(
  parameter int unsigned NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ctrl_t     ctrl_i,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  input  in_item_t  item_i,
  output stat_t     stat_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_o
);

  localparam int unsigned AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  // Joint state memory, valid bit per row stands in for the reset clear
  row_t                  mem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] vld_q;

  logic                  in_fire;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic                  wr_en;
  row_t                  wr_row;
  row_t                  rd_q, row_eff;
  logic                  rd_vld_q;

  // Captured item
  logic                  op_q;
  logic [JOINT_W-1:0]    joint_q;
  angle_t                stand_in_q, low_in_q, high_in_q;
  logic signed [13:0]    act_q;
  logic                  clip_q;
  logic signed [13:0]    act_clip;
  logic                  act_over;
  logic                  in_range;

  // Working registers
  logic signed [28:0]    prod1_q;
  angle_t                raw_q;
  logic signed [33:0]    prod2_q;
  logic signed [16:0]    d_q;

  logic signed [29:0]    mul1_w;
  logic signed [28:0]    rs1;
  logic signed [16:0]    scl;
  logic signed [17:0]    raw_w, lo_w, hi_w, c1, c2;
  logic signed [16:0]    diff;
  logic signed [33:0]    mul2_w;
  logic signed [33:0]    rs2;
  logic signed [17:0]    sm_w, dd_w;
  logic signed [16:0]    lim, d_lim;
  logic                  limited;
  angle_t                tgt;

  logic                  out_free, res_load;
  logic                  res_valid_q;
  out_item_t             res_q, res_d;

  assign in_fire = ctrl_i.in_ready & in_valid_i;
  assign rd_addr = AW'(item_i.joint);
  assign wr_addr = AW'(joint_q);
  assign in_range = (32'(joint_q) < NUM_JOINTS);

  // Clip the action to plus or minus one
  always_comb begin
    act_over = 1'b0;
    act_clip = 14'(item_i.action_value);
    if (item_i.action_value > POS_ONE_Q12) begin
      act_clip = 14'(POS_ONE_Q12);
      act_over = 1'b1;
    end else if (item_i.action_value < NEG_ONE_Q12) begin
      act_clip = 14'(NEG_ONE_Q12);
      act_over = 1'b1;
    end
  end

  // Capture item and read the joint row
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= item_i.operation;
      joint_q    <= item_i.joint;
      stand_in_q <= item_i.stand_angle;
      low_in_q   <= item_i.limit_low;
      high_in_q  <= item_i.limit_high;
      act_q      <= act_clip;
      clip_q     <= act_over;
      rd_q       <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  assign row_eff = rd_vld_q ? rd_q : '0;

  // Scale product and rounding
  assign mul1_w = 30'(act_q) * 30'($signed({1'b0, cfg_i.action_scale}));
  assign rs1    = prod1_q + 29'sd2048;
  assign scl    = rs1[28:12];

  // Stand plus scaled action, clamp low then high
  always_comb begin
    raw_w = 18'(row_eff.stand) + 18'(scl);
    lo_w  = 18'(row_eff.low);
    hi_w  = 18'(row_eff.high);
    c1    = (raw_w < lo_w) ? lo_w : raw_w;
    c2    = (c1 > hi_w) ? hi_w : c1;
  end

  // Blend: raw + coef * (prev - raw) / 2^16, rounded
  assign diff   = 17'(row_eff.target) - 17'(raw_q);
  assign mul2_w = 34'($signed({1'b0, cfg_i.smooth_coef})) * 34'(diff);
  assign rs2    = prod2_q + 34'sd32768;
  assign sm_w   = 18'(raw_q) + rs2[33:16];
  assign dd_w   = sm_w - 18'(row_eff.target);

  // Slew limit
  always_comb begin
    lim     = $signed({2'b00, cfg_i.slew_step});
    limited = 1'b0;
    d_lim   = d_q;
    if (d_q > lim) begin
      d_lim   = lim;
      limited = 1'b1;
    end else if (d_q < -lim) begin
      d_lim   = -lim;
      limited = 1'b1;
    end
    tgt = row_eff.target + d_lim[15:0];
  end

  // Working registers, loaded by the datapath operation
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      DP_SCALE:  prod1_q <= mul1_w[28:0];
      DP_RAW:    raw_q   <= c2[15:0];
      DP_BLEND:  prod2_q <= mul2_w;
      DP_SMOOTH: d_q     <= dd_w[16:0];
      default:   ;
    endcase
  end

  // Write back and result
  assign out_free = !res_valid_q | res_ready_i;

  always_comb begin
    wr_en  = 1'b0;
    wr_row = '{target: tgt, stand: row_eff.stand, low: row_eff.low, high: row_eff.high};
    res_d  = '{joint_out: joint_q, target_angle: tgt, action_clipped: clip_q,
               slew_limited: limited};
    res_load = 1'b0;
    case (ctrl_i.op)
      DP_SLEW: begin
        wr_en    = out_free;
        res_load = out_free;
      end
      DP_SHORT: begin
        res_load = out_free;
        wr_row   = '{target: stand_in_q, stand: stand_in_q, low: low_in_q, high: high_in_q};
        wr_en    = out_free & in_range & (op_q == OP_LOAD);
        res_d    = '{joint_out: joint_q,
                     target_angle: (in_range && op_q == OP_LOAD) ? stand_in_q : '0,
                     action_clipped: 1'b0, slew_limited: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign res_o             = res_q;
  assign stat_o.in_valid   = in_valid_i;
  assign stat_o.short_path = (op_q == OP_LOAD) | !in_range;
  assign stat_o.out_free   = out_free;

endmodule

@@ design/servo_target_smoother_slew_top.sv @@
// Servo target smoother with slew limit, one joint per item.
// Channels: in_i takes items (operation, joint, action, stand, limits);
// out_o gives one result per item (joint, new target, clip and slew flags);
// cfg_i writes action_scale (0), smooth_coef (1) and slew_step (2), always ready.
// A load item stores stand and limits and sets the target to the stand angle.
// An action item clips, scales, clamps, blends with the previous target and
// limits the change, then stores the new target.
// Sequencing: a seven-word control program steps one word per cycle, holding
// while it waits for an item or for a free output register. An action item
// runs through the dispatch, raw, blend, smooth and slew steps; load items and
// items for a joint beyond NUM_JOINTS branch from dispatch to the short step.
// The scale multiply and the blend multiply each have a step of their own.
// in_i is ready again as soon as the result sits in the output register,
// even while the receiver stalls; a stalled result holds the program at its
// last step, so at most one finished result and one item in work coexist.
// Reset clears the configuration to its defaults and marks every joint row
// as zero at once; the block is ready for items straight out of reset.
module servo_target_smoother_slew_top
  import svsl_pkg::*;
#(
  parameter int unsigned NUM_JOINTS = NUM_JOINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svsl_in_if.sink     in_i,
  svsl_out_if.source  out_o,
  svsl_cfg_if.sink    cfg_i
);

  cfg_t      cfg_q;
  ctrl_t     ctrl;
  stat_t     stat;
  in_item_t  item;
  out_item_t res;
  logic      res_valid;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.action_scale <= SCALE_RST;
      cfg_q.smooth_coef  <= COEF_RST;
      cfg_q.slew_step    <= SLEW_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ACTION_SCALE: cfg_q.action_scale <= cfg_i.data[SCALE_W-1:0];
        CFG_SMOOTH_COEF:  cfg_q.smooth_coef  <= cfg_i.data[COEF_W-1:0];
        CFG_SLEW_STEP:    cfg_q.slew_step    <= cfg_i.data[SLEW_W-1:0];
        default:          ;
      endcase
    end
  end

  assign item = '{operation: in_i.operation, joint: in_i.joint,
                  action_value: in_i.action_value, stand_angle: in_i.stand_angle,
                  limit_low: in_i.limit_low, limit_high: in_i.limit_high};

  svsl_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  svsl_dp #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_i.valid),
    .item_i      (item),
    .stat_o      (stat),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready),
    .res_o       (res)
  );

  assign in_i.ready           = ctrl.in_ready;
  assign out_o.valid          = res_valid;
  assign out_o.joint_out      = res.joint_out;
  assign out_o.target_angle   = res.target_angle;
  assign out_o.action_clipped = res.action_clipped;
  assign out_o.slew_limited   = res.slew_limited;

endmodule

@@ design/svsl_chk.sv @@
module svsl_chk
  import svsl_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [JOINT_W-1:0] out_joint_i,
  input angle_t             out_target_i
);

  logic in_fire, out_fire, new_res;
  logic seen_q, fire_q, busy_q;

  assign in_fire  = in_valid_i & in_ready_i;
  assign out_fire = out_valid_i & out_ready_i;
  // A fresh result appears on the output
  assign new_res  = out_valid_i & (!seen_q | fire_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      fire_q <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      seen_q <= out_valid_i;
      fire_q <= out_fire;
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (new_res) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_joint_i) &&
      $stable(out_target_i))
    else $error("stalled result changed");

  // One item in work at a time
  a_in_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("item taken in back-to-back cycles");

  // No result without an item
  a_res_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    new_res |-> busy_q)
    else $error("result without an accepted item");

  // No new item before the previous result is out
  a_in_after_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (!busy_q || new_res))
    else $error("item taken before previous result");

endmodule

bind servo_target_smoother_slew_top svsl_chk u_svsl_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_joint_i  (out_o.joint_out),
  .out_target_i (out_o.target_angle)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import svsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_e;

  // Tracks joint tables and registers, and holds the targets still owed by the block
  class target_tracker;
    logic [SCALE_W-1:0] scale;
    logic [COEF_W-1:0]  coef;
    logic [SLEW_W-1:0]  slew;
    angle_t target_tab [NUM_JOINTS_DEF];
    angle_t stand_tab [NUM_JOINTS_DEF];
    angle_t low_tab [NUM_JOINTS_DEF];
    angle_t high_tab [NUM_JOINTS_DEF];
    out_item_t pending_targets [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned loads;
    int unsigned actions;
    int unsigned clipped;
    int unsigned limited;
    int unsigned reg_writes;

    function new();
      scale = SCALE_RST;
      coef = COEF_RST;
      slew = SLEW_RST;
      for (int i = 0; i < NUM_JOINTS_DEF; i++) begin
        target_tab[i] = '0;
        stand_tab[i] = '0;
        low_tab[i] = '0;
        high_tab[i] = '0;
      end
      errors = 0;
      checked = 0;
      loads = 0;
      actions = 0;
      clipped = 0;
      limited = 0;
      reg_writes = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      reg_writes++;
      case (idx)
        CFG_ACTION_SCALE: scale = val[SCALE_W-1:0];
        CFG_SMOOTH_COEF:  coef = val[COEF_W-1:0];
        CFG_SLEW_STEP:    slew = val[SLEW_W-1:0];
        default: ;
      endcase
    endfunction

    // Load, or clip, scale, clamp, blend, slew-limit; updates the joint tables
    function out_item_t advance_joint(in_item_t it);
      out_item_t r;
      longint act;
      longint raw;
      longint prev;
      longint sm;
      longint d;
      longint lim;
      longint cf;
      int unsigned j;
      r.joint_out = it.joint;
      r.target_angle = '0;
      r.action_clipped = 1'b0;
      r.slew_limited = 1'b0;
      j = 32'(it.joint);
      if (j < NUM_JOINTS_DEF) begin
        if (it.operation == OP_LOAD) begin
          stand_tab[j] = it.stand_angle;
          low_tab[j] = it.limit_low;
          high_tab[j] = it.limit_high;
          target_tab[j] = it.stand_angle;
          r.target_angle = it.stand_angle;
          loads++;
        end else begin
          actions++;
          act = longint'(it.action_value);
          if (act > longint'(POS_ONE_Q12)) begin
            act = longint'(POS_ONE_Q12);
            r.action_clipped = 1'b1;
          end else if (act < longint'(NEG_ONE_Q12)) begin
            act = longint'(NEG_ONE_Q12);
            r.action_clipped = 1'b1;
          end
          // Q8.24 product rounded back to Q4.12
          raw = longint'(stand_tab[j]) + ((act * longint'(scale) + 2048) >>> 12);
          // low first, then high, so high wins when they cross
          if (raw < longint'(low_tab[j])) raw = longint'(low_tab[j]);
          if (raw > longint'(high_tab[j])) raw = longint'(high_tab[j]);
          prev = longint'(target_tab[j]);
          cf = longint'(coef);
          sm = (cf * prev + (65536 - cf) * raw + 32768) >>> 16;
          d = sm - prev;
          lim = longint'(slew);
          if (d > lim) begin
            d = lim;
            r.slew_limited = 1'b1;
          end else if (d < -lim) begin
            d = -lim;
            r.slew_limited = 1'b1;
          end
          target_tab[j] = angle_t'(prev + d);
          r.target_angle = target_tab[j];
          if (r.action_clipped) clipped++;
          if (r.slew_limited) limited++;
        end
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      pending_targets.push_back(advance_joint(it));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_targets.size() == 0) begin
        report_mismatch($sformatf("unexpected result joint %0d target %0d",
                                  got.joint_out, got.target_angle));
      end else begin
        want = pending_targets.pop_front();
        checked++;
        if (got.joint_out !== want.joint_out)
          report_mismatch($sformatf("joint_out got %0d want %0d",
                                    got.joint_out, want.joint_out));
        if (got.target_angle !== want.target_angle)
          report_mismatch($sformatf("joint %0d target_angle got %0d want %0d",
                                    want.joint_out, got.target_angle, want.target_angle));
        if (got.action_clipped !== want.action_clipped)
          report_mismatch($sformatf("joint %0d action_clipped got %b want %b",
                                    want.joint_out, got.action_clipped,
                                    want.action_clipped));
        if (got.slew_limited !== want.slew_limited)
          report_mismatch($sformatf("joint %0d slew_limited got %b want %b",
                                    want.joint_out, got.slew_limited, want.slew_limited));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned cycles = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int unsigned hold_len = 0;
  int unsigned rx_phase = 0;
  int unsigned settings_run = 0;
  target_tracker tracker;

  svsl_in_if  in_bus ();
  svsl_out_if out_bus ();
  svsl_cfg_if cfg_bus ();

  servo_target_smoother_slew_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d targets outstanding", cycles,
               tracker.pending_targets.size());
      $display("FAIL servo_target_smoother_slew_top");
      $finish;
    end
  end

  // Observe all three channels at the clock edge
  always @(posedge clk) begin : observe
    in_item_t seen_in;
    out_item_t seen_out;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) tracker.set_reg(cfg_bus.index, cfg_bus.data);
      if (in_bus.valid && in_bus.ready) begin
        seen_in.operation = in_bus.operation;
        seen_in.joint = in_bus.joint;
        seen_in.action_value = in_bus.action_value;
        seen_in.stand_angle = in_bus.stand_angle;
        seen_in.limit_low = in_bus.limit_low;
        seen_in.limit_high = in_bus.limit_high;
        tracker.note_item(seen_in);
      end
      if (out_bus.valid && out_bus.ready) begin
        seen_out.joint_out = out_bus.joint_out;
        seen_out.target_angle = out_bus.target_angle;
        seen_out.action_clipped = out_bus.action_clipped;
        seen_out.slew_limited = out_bus.slew_limited;
        tracker.check_result(seen_out);
      end
    end
  end

  // Result receiver: stall pattern per mode, plus an occasional long hold-off
  initial begin : receiver
    int unsigned stretch;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        stretch = hold_len;
        hold_len = 0;
        out_bus.ready <= 1'b0;
        for (int k = 0; k < stretch; k++) @(posedge clk);
      end
      rx_phase = (rx_phase + 1) % 7;
      case (rx_mode)
        RX_ALWAYS:  out_bus.ready <= 1'b1;
        RX_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_bus.ready <= !(rx_phase == 2 || rx_phase == 3 || rx_phase == 5);
        default:    out_bus.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic int rand_q12();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic in_item_t load_item(int j, int stand, int lo, int hi);
    in_item_t it;
    it.operation = OP_LOAD;
    it.joint = JOINT_W'(j);
    it.action_value = angle_t'(rand_q12());
    it.stand_angle = angle_t'(stand);
    it.limit_low = angle_t'(lo);
    it.limit_high = angle_t'(hi);
    return it;
  endfunction

  function automatic in_item_t act_item(int j, int a);
    in_item_t it;
    it.operation = OP_ACTION;
    it.joint = JOINT_W'(j);
    it.action_value = angle_t'(a);
    it.stand_angle = angle_t'(rand_q12());
    it.limit_low = angle_t'(rand_q12());
    it.limit_high = angle_t'(rand_q12());
    return it;
  endfunction

  // Mostly actions on a few joints, with loads mixed in to set limits
  function automatic in_item_t random_item();
    in_item_t it;
    int lo;
    int hi;
    int tmp;
    int stand;
    int a;
    int j;
    j = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 15);
    if ($urandom_range(0, 99) < 15) begin
      lo = rand_q12();
      hi = rand_q12();
      stand = rand_q12();
      case ($urandom_range(0, 3))
        0: ;
        1: begin
          lo = int'($urandom_range(0, 12000)) - 6000;
          hi = lo + int'($urandom_range(0, 3000));
        end
        default: begin
          if (lo > hi) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
        end
      endcase
      if (lo <= hi && $urandom_range(0, 4) < 3) stand = lo + int'($urandom_range(0, hi - lo));
      it = load_item(j, stand, lo, hi);
    end else begin
      case ($urandom_range(0, 3))
        0: a = rand_q12();
        1: a = int'($urandom_range(0, 8192)) - 4096;
        2: begin
          a = 4095 + int'($urandom_range(0, 2));
          if ($urandom_range(0, 1) == 0) a = -a;
        end
        default: a = int'($urandom_range(0, 1024)) - 512;
      endcase
      it = act_item(j, a);
    end
    return it;
  endfunction

  // Offer one item and hold it until taken
  task automatic send_item(input in_item_t it);
    in_bus.valid <= 1'b1;
    in_bus.operation <= it.operation;
    in_bus.joint <= it.joint;
    in_bus.action_value <= it.action_value;
    in_bus.stand_angle <= it.stand_angle;
    in_bus.limit_low <= it.limit_low;
    in_bus.limit_high <= it.limit_high;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Random items in bursts with random gaps
  task automatic send_stream(input int unsigned count, input int unsigned max_gap);
    int unsigned left;
    int unsigned burst;
    int unsigned gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) send_item(random_item());
      left -= burst;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Wait until every owed target has come back and the pipeline is quiet
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_targets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  // New register setting, applied only while idle
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] scale_val,
                               input logic [CFG_DATA_W-1:0] coef_val,
                               input logic [CFG_DATA_W-1:0] slew_val);
    settle();
    write_reg(CFG_ACTION_SCALE, scale_val);
    write_reg(CFG_SMOOTH_COEF, coef_val);
    write_reg(CFG_SLEW_STEP, slew_val);
    write_reg(CFG_IDX_UNUSED, 16'($urandom_range(0, 65535)));
    cfg_bus.valid <= 1'b0;
    settings_run++;
  endtask

  initial begin : main
    tracker = new();
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.operation <= OP_ACTION;
    in_bus.joint <= '0;
    in_bus.action_value <= '0;
    in_bus.stand_angle <= '0;
    in_bus.limit_low <= '0;
    in_bus.limit_high <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: never-loaded joints, extremes, clip edges, crossed limits
    send_item(act_item(0, 0));
    send_item(act_item(1, 32767));
    send_item(load_item(15, 32767, -32768, 32767));
    send_item(act_item(15, 32767));
    send_item(act_item(15, -32768));
    send_item(load_item(0, -32768, -32768, 32767));
    send_item(act_item(0, -4097));
    send_item(act_item(0, 4096));
    send_item(load_item(3, 0, 1000, -1000));
    send_item(act_item(3, 4097));
    send_item(act_item(3, -4096));
    send_item(load_item(7, 100, -2000, 2000));
    send_item(act_item(7, 4095));
    send_item(act_item(7, -4095));

    // Full scale, heaviest smoothing, zero slew
    apply_setting(16'd32767, 16'd65535, 16'd0);
    send_item(load_item(5, 0, -32768, 32767));
    send_item(act_item(5, 32767));
    send_item(act_item(5, -32768));
    send_item(act_item(15, 4096));

    // Zero scale, small slew: large jumps get cut both ways
    apply_setting(16'd0, 16'd0, 16'd100);
    send_item(load_item(9, 0, 30000, 32767));
    send_item(act_item(9, 0));
    send_item(act_item(9, -4096));
    send_item(load_item(10, 0, -32768, -30000));
    send_item(act_item(10, 4096));

    // Random phases over several settings and receiver behaviors
    apply_setting(16'd4096, 16'd0, 16'd32767);
    rx_mode = RX_ALWAYS;
    send_stream(180, 0);

    apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    rx_mode = RX_COIN;
    send_stream(180, 8);

    apply_setting(16'd32767, 16'd65535, 16'd32767);
    rx_mode = RX_PATTERN;
    send_stream(150, 4);

    apply_setting(16'd0, 16'd0, 16'd0);
    rx_mode = RX_SPARSE;
    send_stream(100, 3);

    // Long receiver hold-off while items keep coming
    apply_setting(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 32767)));
    rx_mode = RX_ALWAYS;
    hold_len = LONG_HOLD;
    send_stream(180, 0);

    apply_setting(16'($urandom_range(0, 32767)), 16'd49152,
                  16'($urandom_range(1, 500)));
    rx_mode = RX_COIN;
    send_stream(180, 6);

    apply_setting(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    rx_mode = RX_PATTERN;
    hold_len = LONG_HOLD / 2;
    send_stream(150, 2);

    settle();
    $display("covered %0d loads and %0d actions over %0d register settings (%0d writes)",
             tracker.loads, tracker.actions, settings_run, tracker.reg_writes);
    $display("%0d results checked, %0d with action clipped, %0d with slew cut, %0d errors",
             tracker.checked, tracker.clipped, tracker.limited, tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS servo_target_smoother_slew_top");
    end else begin
      $display("FAIL servo_target_smoother_slew_top");
    end
    $finish;
  end

endmodule
